// ----- rtl/pwfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pwfa_pkg
// types, constants and the arctangent table of the plane wave field
// accumulate unit
// ----------------------------------------------------------------------------
package pwfa_pkg;

  localparam int PWFA_CORDIC_STEPS = 24;
  localparam int PWFA_TABLE_LEN    = 32;
  localparam int PWFA_CFG_IDX_W    = 3;

  // Q16 radians to 2^-32 turn
  localparam logic [29:0] PWFA_TURN_PER_RAD = 30'd683565276;
  // cordic gain compensation, Q2.30
  localparam logic [29:0] PWFA_CORDIC_GAIN  = 30'd652032874;

  typedef enum logic [PWFA_CFG_IDX_W-1:0] {
    CFG_WAVE_X       = 3'd0,
    CFG_WAVE_Y       = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_ANGULAR_FREQ = 3'd4,
    CFG_TIME_NOW     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic signed [31:0] amplitude;
    logic signed [31:0] sol_in;
    logic signed [31:0] grad_x_in;
    logic signed [31:0] grad_y_in;
    logic               last_in;
  } pwfa_in_t;

  typedef struct packed {
    logic signed [31:0] sol_out;
    logic signed [31:0] grad_x_out;
    logic signed [31:0] grad_y_out;
    logic               saturated;
    logic               last_out;
  } pwfa_out_t;

  // fields that ride along the pipeline
  typedef struct packed {
    logic signed [31:0] amplitude;
    logic signed [31:0] sol;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic               last;
  } pwfa_carry_t;

  // atan(2^-i) in 2^-32 turn
  function automatic logic [31:0] pwfa_atan(input int unsigned i);
    logic [31:0] r;
    unique case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/plane_wave_field_accumulate_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// plane_wave_field_accumulate_unit
// adds one analytic plane wave to a solution value and its gradient
// ----------------------------------------------------------------------------
// Each input word is one (cell, equation) pair. The unit forms the phase
// k.(centroid - center) - w*t, turns it into an angle, takes cos and sin with
// a pipelined cordic, and adds amp*cos to the solution and -amp*sin*k to the
// two gradient components, saturating each sum to signed Q16.16. A new word
// is taken every cycle unless a finished result is held by out_stall_i. There is one
// register stage per cordic step, min(CORDIC_STEPS,32), plus 8 multiply and round
// stages around it. The whole pipeline advances together: out_stall_i holds every
// stage and shows up on in_stall_o in the same cycle while a result is waiting. The user
// must write configuration registers only while the pipeline is empty; the unit does not check.
// ----------------------------------------------------------------------------
module plane_wave_field_accumulate_unit #(
  parameter int CORDIC_STEPS = pwfa_pkg::PWFA_CORDIC_STEPS
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [pwfa_pkg::PWFA_CFG_IDX_W-1:0] cfg_index_i,
  input  wire [31:0]                       cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  pwfa_pkg::pwfa_in_t               in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output pwfa_pkg::pwfa_out_t              out_data_o
);
  import pwfa_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > PWFA_TABLE_LEN) ? PWFA_TABLE_LEN : CORDIC_STEPS;
  localparam int XW    = 34;   // cordic x and y
  localparam int ZW    = 34;   // cordic residual angle

  // configuration registers
  logic signed [31:0] wave_x_q, wave_y_q, center_x_q, center_y_q, freq_q, time_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_x_q   <= '0;
      wave_y_q   <= '0;
      center_x_q <= '0;
      center_y_q <= '0;
      freq_q     <= '0;
      time_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_WAVE_X:       wave_x_q   <= cfg_data_i;
        CFG_WAVE_Y:       wave_y_q   <= cfg_data_i;
        CFG_CENTER_X:     center_x_q <= cfg_data_i;
        CFG_CENTER_Y:     center_y_q <= cfg_data_i;
        CFG_ANGULAR_FREQ: freq_q     <= cfg_data_i;
        CFG_TIME_NOW:     time_q     <= cfg_data_i;
        default: ;        // unknown index, write dropped
      endcase
    end
  end

  // global advance: every stage moves unless a finished result is held
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------- stage 1: phase products ----------------
  logic signed [32:0] dx, dy;
  logic signed [64:0] px_d, py_d;
  logic signed [63:0] pt_d;
  assign dx   = 33'(in_data_i.cell_x) - 33'(center_x_q);
  assign dy   = 33'(in_data_i.cell_y) - 33'(center_y_q);
  assign px_d = 65'(wave_x_q) * 65'(dx);
  assign py_d = 65'(wave_y_q) * 65'(dy);
  assign pt_d = 64'(freq_q) * 64'(time_q);

  logic               v1_q;
  logic signed [64:0] px_q, py_q;
  logic signed [63:0] pt_q;
  pwfa_carry_t        c1_q;

  // ---------------- stage 2: rounded phase sum ----------------
  logic signed [64:0] rx, ry;
  logic signed [63:0] rt;
  logic signed [50:0] ph_d;
  assign rx   = px_q + 65'sd32768;
  assign ry   = py_q + 65'sd32768;
  assign rt   = pt_q + 64'sd32768;
  assign ph_d = 51'(rx[64:16]) + 51'(ry[64:16]) - 51'(rt[63:16]);

  logic        v2_q;
  logic [47:0] ph_q;     // only the phase modulo 2^48 reaches the angle
  pwfa_carry_t c2_q;

  // ---------------- stage 3: angle scaling, split in two halves ----------------
  logic [53:0] ml_d, mh_d;
  assign ml_d = 54'(ph_q[23:0]) * 54'(PWFA_TURN_PER_RAD);
  assign mh_d = 54'(ph_q[47:24]) * 54'(PWFA_TURN_PER_RAD);

  logic        v3_q;
  logic [47:0] ml_q;
  logic [23:0] mh_q;
  pwfa_carry_t c3_q;

  // ---------------- stage 4: angle, half-plane fold ----------------
  logic [47:0] angp;
  logic [31:0] ang, afold;
  logic        flip_d;
  assign angp   = ml_q + {mh_q, 24'b0};
  assign ang    = angp[47:16];
  assign flip_d = ang[31] ^ ang[30];
  assign afold  = flip_d ? ang + 32'h80000000 : ang;

  logic signed [XW-1:0] cx_q [NSTEP+1];
  logic signed [XW-1:0] cy_q [NSTEP+1];
  logic signed [ZW-1:0] cz_q [NSTEP+1];
  logic                 cv_q [NSTEP+1];
  logic                 cf_q [NSTEP+1];
  pwfa_carry_t          cc_q [NSTEP+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      cv_q[0]  <= 1'b0;
    end else if (en) begin
      v1_q     <= in_valid_i;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      cv_q[0]  <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q           <= px_d;
      py_q           <= py_d;
      pt_q           <= pt_d;
      c1_q.amplitude <= in_data_i.amplitude;
      c1_q.sol       <= in_data_i.sol_in;
      c1_q.grad_x    <= in_data_i.grad_x_in;
      c1_q.grad_y    <= in_data_i.grad_y_in;
      c1_q.last      <= in_data_i.last_in;
      ph_q           <= ph_d[47:0];
      c2_q           <= c1_q;
      ml_q           <= ml_d[47:0];
      mh_q           <= mh_d[23:0];
      c3_q           <= c2_q;
      cx_q[0]        <= XW'(PWFA_CORDIC_GAIN);
      cy_q[0]        <= '0;
      cz_q[0]        <= ZW'($signed(afold));
      cf_q[0]        <= flip_d;
      cc_q[0]        <= c3_q;
    end
  end

  // ---------------- cordic: one rotation per stage ----------------
  for (genvar g = 0; g < NSTEP; g++) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN = ZW'(pwfa_atan(g));
    logic signed [XW-1:0] sx, sy;
    logic                 up;
    assign sx = cy_q[g] >>> g;
    assign sy = cx_q[g] >>> g;
    assign up = !cz_q[g][ZW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[g+1] <= 1'b0;
      end else if (en) begin
        cv_q[g+1] <= cv_q[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cx_q[g+1] <= up ? cx_q[g] - sx : cx_q[g] + sx;
        cy_q[g+1] <= up ? cy_q[g] + sy : cy_q[g] - sy;
        cz_q[g+1] <= up ? cz_q[g] - ATAN : cz_q[g] + ATAN;
        cf_q[g+1] <= cf_q[g];
        cc_q[g+1] <= cc_q[g];
      end
    end
  end

  // ---------------- post a: cos and -sin products ----------------
  logic signed [34:0] cosv;
  logic signed [35:0] nsin;
  logic signed [66:0] pc_d;
  logic signed [67:0] pwx_d, pwy_d;
  assign cosv  = cf_q[NSTEP] ? -35'(cx_q[NSTEP]) : 35'(cx_q[NSTEP]);
  assign nsin  = cf_q[NSTEP] ? 36'(cy_q[NSTEP]) : -36'(cy_q[NSTEP]);
  assign pc_d  = 67'(cc_q[NSTEP].amplitude) * 67'(cosv);
  assign pwx_d = 68'(wave_x_q) * 68'(nsin);
  assign pwy_d = 68'(wave_y_q) * 68'(nsin);

  logic               va_q;
  logic signed [66:0] pc_q;
  logic signed [67:0] pwx_q, pwy_q;
  pwfa_carry_t        ca_q;

  // ---------------- post b: round to Q16 ----------------
  logic signed [66:0] rc;
  logic signed [67:0] rwx, rwy;
  assign rc  = pc_q + 67'sd536870912;
  assign rwx = pwx_q + 68'sd536870912;
  assign rwy = pwy_q + 68'sd536870912;

  logic               vb_q;
  logic signed [36:0] tsol_q;
  logic signed [37:0] wsx_q, wsy_q;
  pwfa_carry_t        cb_q;

  // ---------------- post c: gradient products ----------------
  logic signed [69:0] mgx_d, mgy_d;
  assign mgx_d = 70'(cb_q.amplitude) * 70'(wsx_q);
  assign mgy_d = 70'(cb_q.amplitude) * 70'(wsy_q);

  logic               vc_q;
  logic signed [69:0] mgx_q, mgy_q;
  logic signed [36:0] tsol_c_q;
  pwfa_carry_t        cq_q;

  // ---------------- post d: round, add, saturate ----------------
  function automatic logic [32:0] sat32(input logic signed [54:0] v);
    logic [32:0] r;
    if (v > 55'sd2147483647) begin
      r = {1'b1, 32'h7FFFFFFF};
    end else if (v < -55'sd2147483648) begin
      r = {1'b1, 32'h80000000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  logic signed [69:0] rgx, rgy;
  logic [32:0]        ssol, sgx, sgy;
  pwfa_out_t          out_d;
  assign rgx  = mgx_q + 70'sd32768;
  assign rgy  = mgy_q + 70'sd32768;
  assign ssol = sat32(55'(cq_q.sol) + 55'(tsol_c_q));
  assign sgx  = sat32(55'(cq_q.grad_x) + 55'($signed(rgx[69:16])));
  assign sgy  = sat32(55'(cq_q.grad_y) + 55'($signed(rgy[69:16])));

  always_comb begin
    out_d.sol_out    = ssol[31:0];
    out_d.grad_x_out = sgx[31:0];
    out_d.grad_y_out = sgy[31:0];
    out_d.saturated  = ssol[32] | sgx[32] | sgy[32];
    out_d.last_out   = cq_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      va_q        <= cv_q[NSTEP];
      vb_q        <= va_q;
      vc_q        <= vb_q;
      out_valid_o <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pc_q       <= pc_d;
      pwx_q      <= pwx_d;
      pwy_q      <= pwy_d;
      ca_q       <= cc_q[NSTEP];
      tsol_q     <= rc[66:30];
      wsx_q      <= rwx[67:30];
      wsy_q      <= rwy[67:30];
      cb_q       <= ca_q;
      mgx_q      <= mgx_d;
      mgy_q      <= mgy_d;
      tsol_c_q   <= tsol_q;
      cq_q       <= cb_q;
      out_data_o <= out_d;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the plane wave field accumulate unit
// ----------------------------------------------------------------------------
// A directed table of words and then random bursts with random input gaps go
// through the unit under random output stalls. A fixed-point model of the
// phase, the cordic and the saturating sums predicts every result not typed
// in; each output word is compared field by field with the oldest expected
// result. Configuration is written between phases, once the pipeline drains.
// ----------------------------------------------------------------------------
module tb;
  import pwfa_pkg::*;

  localparam int  STEPS     = PWFA_CORDIC_STEPS;
  localparam int  LATENCY   = ((STEPS < 32) ? STEPS : 32) + 9;
  localparam int  N_RANDOM  = 500;
  localparam longint LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [PWFA_CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pwfa_in_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pwfa_out_t   out_word;

  plane_wave_field_accumulate_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of the register file
  longint wave_k_x, wave_k_y, ctr_x, ctr_y, omega, t_now;

  pwfa_out_t field_queue[$];
  int        errors = 0;
  longint    cycle = 0;

  // floor shift and round half up
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rhu(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] atan_turn(int i);
    logic [31:0] t [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};
    return t[i];
  endfunction

  function automatic longint clamp32(longint v, inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic pwfa_out_t wave_update(pwfa_in_t w);
    longint    ph, z, x, y, dx, dy, c, s, wsx, wsy, tsol, tgx, tgy, amp;
    logic [63:0] prod;
    logic [31:0] ang, a;
    logic      flip, flag;
    pwfa_out_t r;
    amp = longint'(w.amplitude);
    ph = rhu(wave_k_x * (longint'(w.cell_x) - ctr_x), 16)
       + rhu(wave_k_y * (longint'(w.cell_y) - ctr_y), 16)
       - rhu(omega * t_now, 16);
    prod = 64'(ph) * 64'd683565276;
    ang = prod[47:16];
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    a = flip ? ang + 32'h80000000 : ang;
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    tsol = rhu(amp * c, 30);
    wsx = rhu(wave_k_x * (-s), 30);
    wsy = rhu(wave_k_y * (-s), 30);
    tgx = rhu(amp * wsx, 16);
    tgy = rhu(amp * wsy, 16);
    flag = 1'b0;
    r.sol_out    = 32'(clamp32(longint'(w.sol_in) + tsol, flag));
    r.grad_x_out = 32'(clamp32(longint'(w.grad_x_in) + tgx, flag));
    r.grad_y_out = 32'(clamp32(longint'(w.grad_y_in) + tgy, flag));
    r.saturated  = flag;
    r.last_out   = w.last_in;
    return r;
  endfunction

  // output side: random stall pattern and the scoreboard
  int stall_mode = 0;
  always @(negedge clk) begin
    cycle <= cycle + 1;
    if (cycle % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 15) < 13);
    endcase
  end

  always @(posedge clk) begin
    pwfa_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (field_queue.size() == 0) begin
        $error("unexpected output word %h", out_word);
        errors++;
      end else begin
        want = field_queue.pop_front();
        if (out_word.sol_out !== want.sol_out) begin
          $error("sol_out expected %h actual %h", want.sol_out, out_word.sol_out);
          errors++;
        end
        if (out_word.grad_x_out !== want.grad_x_out) begin
          $error("grad_x_out expected %h actual %h", want.grad_x_out, out_word.grad_x_out);
          errors++;
        end
        if (out_word.grad_y_out !== want.grad_y_out) begin
          $error("grad_y_out expected %h actual %h", want.grad_y_out, out_word.grad_y_out);
          errors++;
        end
        if (out_word.saturated !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated, out_word.saturated);
          errors++;
        end
        if (out_word.last_out !== want.last_out) begin
          $error("last_out expected %b actual %b", want.last_out, out_word.last_out);
          errors++;
        end
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycle > LIMIT) begin
      $display("plane_wave_field_accumulate_unit verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WAVE_X:       wave_k_x = longint'($signed(val));
      CFG_WAVE_Y:       wave_k_y = longint'($signed(val));
      CFG_CENTER_X:     ctr_x    = longint'($signed(val));
      CFG_CENTER_Y:     ctr_y    = longint'($signed(val));
      CFG_ANGULAR_FREQ: omega    = longint'($signed(val));
      CFG_TIME_NOW:     t_now    = longint'($signed(val));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // out-of-range index: no register may change
  task automatic write_bad_index();
    cfg_valid <= 1'b1;
    cfg_index <= 3'd6 + 3'($urandom_range(0, 1));
    cfg_data  <= $urandom;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait until every prediction has been matched, then let the pipe settle
  task automatic drain();
    while (field_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // one input word, optionally with its result typed in
  task automatic send_word(pwfa_in_t w, bit typed, pwfa_out_t typed_res);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    field_queue.push_back(typed ? typed_res : wave_update(w));
    @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 8)) << 16;
      3: return 32'($signed($urandom_range(0, 262144)) - 131072);
      default: return $urandom;
    endcase
  endfunction

  function automatic pwfa_in_t rnd_word();
    pwfa_in_t w;
    w.cell_x    = rnd_val();
    w.cell_y    = rnd_val();
    w.amplitude = rnd_val();
    w.sol_in    = rnd_val();
    w.grad_x_in = rnd_val();
    w.grad_y_in = rnd_val();
    w.last_in   = $urandom_range(0, 1);
    return w;
  endfunction

  task automatic random_phase(int n);
    int left;
    int gap;
    pwfa_in_t w;
    left = n;
    while (left > 0) begin
      // burst, then a gap
      for (int b = $urandom_range(1, 40); b > 0 && left > 0; b--) begin
        w = rnd_word();
        send_word(w, 1'b0, '0);
        left--;
      end
      gap = $urandom_range(0, 6);
      if (gap > 0 || left == 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  typedef struct {
    pwfa_in_t  w;
    bit        typed;
    pwfa_out_t res;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    wave_k_x = 0; wave_k_y = 0; ctr_x = 0; ctr_y = 0; omega = 0; t_now = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // after reset phase is zero: cos is the gain product, sin is zero
    r.w = '0; r.w.sol_in = 32'h7FFFFFFF; r.w.amplitude = 32'h00010000;
    r.w.last_in = 1'b1; r.typed = 1'b1;
    r.res = '{32'h7FFFFFFF, 32'h0, 32'h0, 1'b1, 1'b1}; rows.push_back(r);
    r.w = '0; r.w.sol_in = 32'h80000000; r.w.amplitude = 32'h80000000;
    r.typed = 1'b1; r.res = '{32'h80000000, 32'h0, 32'h0, 1'b1, 1'b0};
    rows.push_back(r);
    r.w = '0; r.w.grad_x_in = 32'h7FFFFFFF; r.w.grad_y_in = 32'h80000000;
    r.typed = 1'b1; r.res = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 1'b0, 1'b0};
    rows.push_back(r);
    r.w = '0; r.typed = 1'b1; r.res = '0; rows.push_back(r);
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);
    in_valid <= 1'b0;
    drain();

    // extremes of the wave and huge phases
    write_reg(CFG_WAVE_X, 32'h7FFFFFFF);
    write_reg(CFG_WAVE_Y, 32'h80000000);
    write_reg(CFG_CENTER_X, 32'h80000000);
    write_reg(CFG_CENTER_Y, 32'h7FFFFFFF);
    write_reg(CFG_ANGULAR_FREQ, 32'h7FFFFFFF);
    write_reg(CFG_TIME_NOW, 32'h80000000);
    write_bad_index();
    rows.delete();
    for (int i = 0; i < 16; i++) begin
      r.w = rnd_word(); r.typed = 1'b0; r.res = '0;
      if (i < 4) begin
        r.w.cell_x = i[0] ? 32'h7FFFFFFF : 32'h80000000;
        r.w.cell_y = i[1] ? 32'h7FFFFFFF : 32'h80000000;
        r.w.amplitude = i[0] ? 32'h80000000 : 32'h7FFFFFFF;
      end
      rows.push_back(r);
    end
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);
    in_valid <= 1'b0;
    drain();

    // random settings, small to moderate wave vectors then full range
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_WAVE_X, ph < 3 ? 32'($signed($urandom_range(0, 524288)) - 262144)
                                    : $urandom);
      write_reg(CFG_WAVE_Y, ph < 3 ? 32'($signed($urandom_range(0, 524288)) - 262144)
                                    : $urandom);
      write_reg(CFG_CENTER_X, rnd_val());
      write_reg(CFG_CENTER_Y, rnd_val());
      write_reg(CFG_ANGULAR_FREQ, rnd_val());
      write_reg(CFG_TIME_NOW, rnd_val());
      random_phase(N_RANDOM / 5);
      // sender holds off until the pipe is empty before the next setting
      drain();
    end

    write_reg(CFG_WAVE_X, 32'h0);
    write_reg(CFG_WAVE_Y, 32'h0);
    write_reg(CFG_ANGULAR_FREQ, 32'h0);
    random_phase(20);
    drain();

    if (errors == 0) begin
      $display("plane_wave_field_accumulate_unit verification clean");
    end else begin
      $display("plane_wave_field_accumulate_unit verification failed");
    end
    $finish;
  end
endmodule
